[design/dllm_pkg.sv]
// ----------------------------------------------------------------------------
// dllm_pkg
// Shared field widths, operation codes and controller/datapath handshake
// types for the doubly linked list manager.
// ----------------------------------------------------------------------------
package dllm_pkg;

    localparam int ENTRY_W = 6;
    localparam int KIND_W  = 3;
    localparam int LEN_W   = 7;

    // Operation codes carried on the kind field; codes 6 and 7 mean nothing
    typedef enum logic [KIND_W-1:0] {
        KIND_INS_FIRST  = 3'd0,
        KIND_INS_LAST   = 3'd1,
        KIND_INS_BEFORE = 3'd2,
        KIND_TAKE_ENTRY = 3'd3,
        KIND_TAKE_FIRST = 3'd4,
        KIND_TAKE_LAST  = 3'd5
    } t_kind;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;  // latch the incoming word, launch link reads
        logic eval;     // check legality, do first link write and list update
        logic link;     // second link write for inserts
    } t_cmd;

    // Status from datapath to controller, valid during eval
    typedef struct packed {
        logic legal;
        logic insert;
    } t_status;

endpackage

[design/dllm_ctrl.sv]
// ----------------------------------------------------------------------------
// dllm_ctrl
// Sequencer for one list operation: capture, evaluate, optional link pass,
// then a one-cycle done strobe.
// ----------------------------------------------------------------------------
module dllm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    output logic             o_done,
    output dllm_pkg::t_cmd   o_cmd,
    input  dllm_pkg::t_status i_status
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_LINK
    } t_state;

    t_state r_state;
    logic   r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        r_state <= ST_EVAL;
                    end
                end
                ST_EVAL: begin
                    if (i_status.legal && i_status.insert) begin
                        r_state <= ST_LINK;
                    end else begin
                        r_state <= ST_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                ST_LINK: begin
                    r_state <= ST_IDLE;
                    r_done  <= 1'b1;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy          = (r_state != ST_IDLE);
    assign o_done        = r_done;
    assign o_cmd.capture = (r_state == ST_IDLE) && start;
    assign o_cmd.eval    = (r_state == ST_EVAL);
    assign o_cmd.link    = (r_state == ST_LINK);

endmodule

[design/dllm_datapath.sv]
// ----------------------------------------------------------------------------
// dllm_datapath
// Link tables (prev and next memories), head, tail, count and membership
// bits, with the legality checks and link updates of each operation.
// ----------------------------------------------------------------------------
module dllm_datapath #(
    parameter int POOL_SIZE = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dllm_pkg::t_cmd                i_cmd,
    output dllm_pkg::t_status             o_status,
    input  logic [dllm_pkg::KIND_W-1:0]   i_kind,
    input  logic [dllm_pkg::ENTRY_W-1:0]  i_entry,
    input  logic [dllm_pkg::ENTRY_W-1:0]  i_before_entry,
    output logic [dllm_pkg::ENTRY_W-1:0]  o_taken_entry,
    output logic                          o_taken_valid,
    output logic                          o_error,
    output logic [dllm_pkg::LEN_W-1:0]    o_length,
    output logic                          o_is_empty,
    output logic [dllm_pkg::ENTRY_W-1:0]  o_first_entry,
    output logic [dllm_pkg::ENTRY_W-1:0]  o_last_entry
);

    localparam int IW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int LW = $clog2(POOL_SIZE + 1);
    localparam logic [LW-1:0] NIL = LW'(POOL_SIZE);

    // link memories
    logic [LW-1:0] r_prev_link [POOL_SIZE];
    logic [LW-1:0] r_next_link [POOL_SIZE];
    logic [LW-1:0] r_prev_rd;
    logic [LW-1:0] r_next_rd;

    // list state
    logic [POOL_SIZE-1:0] r_member;
    logic [LW-1:0]        r_head;
    logic [LW-1:0]        r_tail;
    logic [LW-1:0]        r_count;

    // membership of the incoming entry and anchor, sampled with the link reads
    logic                 r_e_mem;
    logic                 r_b_mem;

    // captured word and saved neighbors
    logic [dllm_pkg::KIND_W-1:0]  r_kind;
    logic [dllm_pkg::ENTRY_W-1:0] r_entry;
    logic [dllm_pkg::ENTRY_W-1:0] r_before;
    logic [LW-1:0]                r_p;
    logic [LW-1:0]                r_n;
    logic [LW-1:0]                r_e;

    // result word
    logic [dllm_pkg::ENTRY_W-1:0] r_taken;
    logic                         r_taken_valid;
    logic                         r_error;

    // read address from the incoming word
    logic [31:0]   w_in_e32;
    logic [31:0]   w_in_b32;
    logic [IW-1:0] w_in_e_idx;
    logic [IW-1:0] w_in_b_idx;
    logic [LW-1:0] w_rd_tgt;
    logic [IW-1:0] w_prev_ra;
    logic [IW-1:0] w_next_ra;

    // evaluation
    logic [31:0]   w_e32;
    logic [31:0]   w_b32;
    logic [LW-1:0] w_e_lw;
    logic [LW-1:0] w_b_lw;
    logic [IW-1:0] w_e_idx;
    logic          w_e_in;
    logic          w_b_in;
    logic          w_e_mem;
    logic          w_b_mem;
    logic [LW-1:0] w_tgt;
    logic [LW-1:0] w_p;
    logic [LW-1:0] w_n;
    logic          w_legal;
    logic          w_insert;
    logic          w_take;

    // memory write ports
    logic          w_prev_we;
    logic [IW-1:0] w_prev_wa;
    logic [LW-1:0] w_prev_wd;
    logic          w_next_we;
    logic [IW-1:0] w_next_wa;
    logic [LW-1:0] w_next_wd;

    logic [31:0]   w_head32;
    logic [31:0]   w_tail32;
    logic [31:0]   w_count32;
    logic [31:0]   w_tgt32;

    // launch reads at capture: prev at the anchor for insert before, otherwise
    // at the target; next always at the target (the entry, or head/tail for takes)
    always_comb begin
        w_in_e32   = 32'(i_entry);
        w_in_b32   = 32'(i_before_entry);
        w_in_e_idx = w_in_e32[IW-1:0];
        w_in_b_idx = w_in_b32[IW-1:0];
        case (i_kind)
            dllm_pkg::KIND_TAKE_FIRST: w_rd_tgt = r_head;
            dllm_pkg::KIND_TAKE_LAST:  w_rd_tgt = r_tail;
            default:                   w_rd_tgt = w_in_e32[LW-1:0];
        endcase
        w_next_ra = w_rd_tgt[IW-1:0];
        if (i_kind == dllm_pkg::KIND_INS_BEFORE) begin
            w_prev_ra = w_in_b_idx;
        end else begin
            w_prev_ra = w_rd_tgt[IW-1:0];
        end
    end

    // legality and neighbor selection
    always_comb begin
        w_e32   = 32'(r_entry);
        w_b32   = 32'(r_before);
        w_e_lw  = w_e32[LW-1:0];
        w_b_lw  = w_b32[LW-1:0];
        w_e_idx = w_e32[IW-1:0];
        w_e_in  = (w_e32 < 32'(POOL_SIZE));
        w_b_in  = (w_b32 < 32'(POOL_SIZE));
        w_e_mem = w_e_in && r_e_mem;
        w_b_mem = w_b_in && r_b_mem;
        w_tgt   = w_e_lw;
        w_p     = r_prev_rd;
        w_n     = r_next_rd;
        w_legal  = 1'b0;
        w_insert = 1'b0;
        w_take   = 1'b0;
        case (r_kind)
            dllm_pkg::KIND_INS_FIRST: begin
                w_insert = 1'b1;
                w_legal  = w_e_in && !w_e_mem;
                w_p      = NIL;
                w_n      = r_head;
            end
            dllm_pkg::KIND_INS_LAST: begin
                w_insert = 1'b1;
                w_legal  = w_e_in && !w_e_mem;
                w_p      = r_tail;
                w_n      = NIL;
            end
            dllm_pkg::KIND_INS_BEFORE: begin
                w_insert = 1'b1;
                w_legal  = w_e_in && !w_e_mem && w_b_mem;
                w_p      = r_prev_rd;
                w_n      = w_b_lw;
            end
            dllm_pkg::KIND_TAKE_ENTRY: begin
                w_take  = 1'b1;
                w_legal = w_e_mem;
            end
            dllm_pkg::KIND_TAKE_FIRST: begin
                w_take  = 1'b1;
                w_legal = (r_count != '0) && (r_head != NIL);
                w_tgt   = r_head;
            end
            dllm_pkg::KIND_TAKE_LAST: begin
                w_take  = 1'b1;
                w_legal = (r_count != '0) && (r_tail != NIL);
                w_tgt   = r_tail;
            end
            default: begin
                w_legal = 1'b0;
            end
        endcase
    end

    assign o_status.legal  = w_legal;
    assign o_status.insert = w_insert;

    // write port selection
    always_comb begin
        w_prev_we = 1'b0;
        w_prev_wa = w_e_idx;
        w_prev_wd = w_p;
        w_next_we = 1'b0;
        w_next_wa = w_e_idx;
        w_next_wd = w_n;
        if (i_cmd.eval && w_legal && w_insert) begin
            // new entry's own links
            w_prev_we = 1'b1;
            w_next_we = 1'b1;
        end else if (i_cmd.eval && w_legal && w_take) begin
            // bridge the neighbors over the removed entry
            w_prev_we = (w_n != NIL);
            w_prev_wa = w_n[IW-1:0];
            w_prev_wd = w_p;
            w_next_we = (w_p != NIL);
            w_next_wa = w_p[IW-1:0];
            w_next_wd = w_n;
        end else if (i_cmd.link) begin
            // point the neighbors at the new entry
            w_prev_we = (r_n != NIL);
            w_prev_wa = r_n[IW-1:0];
            w_prev_wd = r_e;
            w_next_we = (r_p != NIL);
            w_next_wa = r_p[IW-1:0];
            w_next_wd = r_e;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_prev_we) begin
            r_prev_link[w_prev_wa] <= w_prev_wd;
        end
        r_prev_rd <= r_prev_link[w_prev_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_next_we) begin
            r_next_link[w_next_wa] <= w_next_wd;
        end
        r_next_rd <= r_next_link[w_next_ra];
    end

    // sample membership of the incoming word alongside the link reads
    always_ff @(posedge i_clk) begin
        r_e_mem <= r_member[w_in_e_idx];
        r_b_mem <= r_member[w_in_b_idx];
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind   <= i_kind;
            r_entry  <= i_entry;
            r_before <= i_before_entry;
        end
        if (i_cmd.eval) begin
            r_p           <= w_p;
            r_n           <= w_n;
            r_e           <= w_e_lw;
            r_error       <= !w_legal;
            r_taken_valid <= w_legal && w_take;
            r_taken       <= (w_legal && w_take) ? w_tgt32[dllm_pkg::ENTRY_W-1:0] : '0;
        end
    end

    assign w_tgt32 = 32'(w_tgt);

    // list state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_member <= '0;
            r_head   <= NIL;
            r_tail   <= NIL;
            r_count  <= '0;
        end else if (i_cmd.eval && w_legal) begin
            if (w_insert) begin
                r_member[w_e_idx] <= 1'b1;
                r_count           <= r_count + LW'(1);
                if (w_p == NIL) begin
                    r_head <= w_e_lw;
                end
                if (w_n == NIL) begin
                    r_tail <= w_e_lw;
                end
            end else begin
                r_member[w_tgt[IW-1:0]] <= 1'b0;
                r_count                 <= r_count - LW'(1);
                if (w_p == NIL) begin
                    r_head <= w_n;
                end
                if (w_n == NIL) begin
                    r_tail <= w_p;
                end
            end
        end
    end

    // result fields
    assign w_head32  = 32'(r_head);
    assign w_tail32  = 32'(r_tail);
    assign w_count32 = 32'(r_count);

    assign o_taken_entry = r_taken;
    assign o_taken_valid = r_taken_valid;
    assign o_error       = r_error;
    assign o_length      = w_count32[dllm_pkg::LEN_W-1:0];
    assign o_is_empty    = (r_count == '0);
    assign o_first_entry = (r_head != NIL) ? w_head32[dllm_pkg::ENTRY_W-1:0] : '0;
    assign o_last_entry  = (r_tail != NIL) ? w_tail32[dllm_pkg::ENTRY_W-1:0] : '0;

endmodule

[design/doubly_linked_list_manager.sv]
// ----------------------------------------------------------------------------
// doubly_linked_list_manager
// Ordered doubly linked list over a fixed pool of entry indices.
// ----------------------------------------------------------------------------
// Each word on start is one list operation (insert first, insert last,
// insert before a member, take an entry, take first, take last). The block
// accepts a word when start is high and busy is low, and answers every word
// with exactly one result, shown for a single cycle with o_done high; the
// receiver cannot stall it, so sample the result ports on o_done. Each
// operation reads the link memories, then does the first link write and
// list update; a take or an illegal operation then completes, while an
// insert does one more write, since each link memory has a single write
// port and an insert touches two entries of the same table. The next word
// may be issued in the cycle o_done is high. Illegal operations (inserting a
// member, taking a non-member, taking from an empty list, inserting before a
// non-member, unused kind codes, indices beyond the pool) raise o_error and
// leave the list unchanged. Link tables are not cleared at reset; only
// membership, head, tail and count are, so the block is ready at once.
// ----------------------------------------------------------------------------
module doubly_linked_list_manager #(
    parameter int POOL_SIZE = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [dllm_pkg::KIND_W-1:0]   i_kind,
    input  logic [dllm_pkg::ENTRY_W-1:0]  i_entry,
    input  logic [dllm_pkg::ENTRY_W-1:0]  i_before_entry,
    output logic                          o_done,
    output logic [dllm_pkg::ENTRY_W-1:0]  o_taken_entry,
    output logic                          o_taken_valid,
    output logic                          o_error,
    output logic [dllm_pkg::LEN_W-1:0]    o_length,
    output logic                          o_is_empty,
    output logic [dllm_pkg::ENTRY_W-1:0]  o_first_entry,
    output logic [dllm_pkg::ENTRY_W-1:0]  o_last_entry
);

    dllm_pkg::t_cmd    w_cmd;
    dllm_pkg::t_status w_status;

    // sequence the operation
    dllm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .o_done   (o_done),
        .o_cmd    (w_cmd),
        .i_status (w_status)
    );

    // hold the list and its link tables
    dllm_datapath #(
        .POOL_SIZE (POOL_SIZE)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_kind         (i_kind),
        .i_entry        (i_entry),
        .i_before_entry (i_before_entry),
        .o_taken_entry  (o_taken_entry),
        .o_taken_valid  (o_taken_valid),
        .o_error        (o_error),
        .o_length       (o_length),
        .o_is_empty     (o_is_empty),
        .o_first_entry  (o_first_entry),
        .o_last_entry   (o_last_entry)
    );

endmodule
